// ===== src/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int MAX_RES    = 5;
    localparam int NUM_W      = $clog2(MAX_RES + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CC_BS     = 8'h08;
    localparam logic [7:0] CC_LF     = 8'h0A;
    localparam logic [7:0] CC_CR     = 8'h0D;
    localparam logic [7:0] CC_TAB    = 8'h09;
    localparam logic [7:0] CC_FF     = 8'h0C;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_BSLASH,
        PH_HEX
    } phase_t;

    // one request: the result bytes caused by one input byte
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;  // bytes[0] goes out first
        logic [NUM_W-1:0]        num;
        logic                    eos;
        logic                    bare;
    } cmd_t;

endpackage

// ===== src/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: takes one raw byte per accept and builds a request with
// the unescaped bytes it produces.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_accept,
    input  logic [7:0]    in_byte,
    input  logic          first_item,
    input  logic          last_item,
    input  logic          quoted,
    output logic          push,
    output jsu_pkg::cmd_t push_cmd
);
    import jsu_pkg::*;

    phase_t          phase_reg, phase_next, ph;
    logic [1:0]      cnt_reg, cnt_next, cnt;
    logic            strip_reg, strip_next, strip;
    logic [2:0][7:0] held_reg, held_next, held;
    logic            run_proc;
    logic [15:0]     code;
    cmd_t            c;

    function automatic logic is_hex(logic [7:0] b);
        return b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] hex_val(logic [7:0] b);
        return b[6] ? 4'(b[3:0] + 4'd9) : b[3:0];
    endfunction

    function automatic cmd_t put(cmd_t ci, logic [7:0] b);
        cmd_t co;
        co = ci;
        co.bytes[co.num] = b;
        co.num = co.num + NUM_W'(1);
        return co;
    endfunction

    function automatic cmd_t put_flush(cmd_t ci, logic [2:0][7:0] h, logic [1:0] n);
        cmd_t co;
        co = put(ci, CH_U);
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < n) begin
                co = put(co, h[i]);
            end
        end
        return co;
    endfunction

    function automatic cmd_t put_utf8(cmd_t ci, logic [15:0] v);
        cmd_t co;
        co = ci;
        if (v < 16'h0080) begin
            co = put(co, v[7:0]);
        end else if (v < 16'h0800) begin
            co = put(co, {3'b110, v[10:6]});
            co = put(co, {2'b10, v[5:0]});
        end else begin
            co = put(co, {4'b1110, v[15:12]});
            co = put(co, {2'b10, v[11:6]});
            co = put(co, {2'b10, v[5:0]});
        end
        return co;
    endfunction

    always_comb begin
        c     = '0;
        ph    = phase_reg;
        cnt   = cnt_reg;
        strip = strip_reg;
        held  = held_reg;
        code  = {hex_val(held_reg[0]), hex_val(held_reg[1]),
                 hex_val(held_reg[2]), hex_val(in_byte)};
        if (first_item) begin
            ph    = PH_NORMAL;
            cnt   = '0;
            strip = quoted;
        end
        run_proc = last_item ? !strip : !(first_item && strip);

        if (run_proc) begin
            case (ph)
                PH_BSLASH: begin
                    ph = PH_NORMAL;
                    case (in_byte)
                        CH_B:    c = put(c, CC_BS);
                        CH_N:    c = put(c, CC_LF);
                        CH_R:    c = put(c, CC_CR);
                        CH_T:    c = put(c, CC_TAB);
                        CH_F:    c = put(c, CC_FF);
                        CH_U: begin
                            ph  = PH_HEX;
                            cnt = '0;
                        end
                        default: c = put(c, in_byte);
                    endcase
                end
                PH_HEX: begin
                    if (is_hex(in_byte)) begin
                        if (cnt == 2'd3) begin
                            c   = put_utf8(c, code);
                            cnt = '0;
                            ph  = PH_NORMAL;
                        end else begin
                            held[cnt] = in_byte;
                            cnt       = cnt + 2'd1;
                        end
                    end else begin
                        c   = put_flush(c, held, cnt);
                        cnt = '0;
                        if (in_byte == CH_BSLASH) begin
                            ph = PH_BSLASH;
                        end else begin
                            ph = PH_NORMAL;
                            c  = put(c, in_byte);
                        end
                    end
                end
                default: begin
                    if (in_byte == CH_BSLASH) begin
                        ph = PH_BSLASH;
                    end else begin
                        c = put(c, in_byte);
                    end
                end
            endcase
        end

        if (last_item) begin
            if (ph == PH_BSLASH && strip) begin
                c = put(c, in_byte);
            end else if (ph == PH_HEX) begin
                c = put_flush(c, held, cnt);
            end
            if (c.num == '0) begin
                c.num  = NUM_W'(1);
                c.bare = 1'b1;
            end
            c.eos = 1'b1;
            ph    = PH_NORMAL;
            cnt   = '0;
            strip = 1'b0;
        end

        phase_next = ph;
        cnt_next   = cnt;
        strip_next = strip;
        held_next  = held;
    end

    assign push     = in_accept && (c.num != '0);
    assign push_cmd = c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_NORMAL;
            cnt_reg   <= '0;
            strip_reg <= 1'b0;
        end else if (in_accept) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            strip_reg <= strip_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            held_reg <= held_next;
        end
    end

endmodule

// ===== src/jsu_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// jsu_cmd_fifo
// Short request queue between the escape decoder and the byte sender.
// ----------------------------------------------------------------------------
module jsu_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  jsu_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output jsu_pkg::cmd_t pop_cmd,
    output logic          empty
);
    import jsu_pkg::*;

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;

    assign full    = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + FIFO_AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + FIFO_AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + FIFO_CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - FIFO_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back
// Byte sender: unpacks queued requests onto the output stream, one byte
// per transfer, with optional ASCII lowercasing.
// ----------------------------------------------------------------------------
module jsu_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          lower,
    input  logic          empty,
    input  jsu_pkg::cmd_t pop_cmd,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast,
    output logic [0:0]    m_tuser
);
    import jsu_pkg::*;

    logic             busy_reg, busy_next;
    cmd_t             cur_reg, cur_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic             hs;
    logic             free;
    logic [7:0]       b0;

    assign hs   = busy_reg && m_tready;
    assign free = !busy_reg || (hs && rem_reg == NUM_W'(1));
    assign pop  = free && !empty;

    always_comb begin
        busy_next = busy_reg;
        cur_next  = cur_reg;
        rem_next  = rem_reg;
        if (free) begin
            busy_next = !empty;
            cur_next  = pop_cmd;
            rem_next  = pop_cmd.num;
        end else if (hs) begin
            cur_next.bytes = {8'h00, cur_reg.bytes[MAX_RES-1:1]};
            rem_next       = rem_reg - NUM_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        rem_reg <= rem_next;
    end

    assign b0       = cur_reg.bytes[0];
    assign m_tvalid = busy_reg;
    assign m_tdata  = (lower && b0 >= CH_UP_A && b0 <= CH_UP_Z) ? (b0 | CASE_BIT) : b0;
    assign m_tlast  = cur_reg.eos && (rem_reg == NUM_W'(1));
    assign m_tuser  = !cur_reg.bare;

endmodule

// ===== src/json_string_unescape.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape
// Streaming JSON string unescaper: one raw byte in, zero to five bytes out.
// Path: a request is written to the queue, then loaded into the sender register.
// Throughput: one input byte per cycle while the 4-deep request queue has
// room; output runs at one byte per cycle while m_tready is high, so an
// input producing N bytes (N up to 5) holds the sender for N transfers.
// Reset: synchronous active-low aresetn clears escape state, queue and
// output valid, and sets lowercase_output to 0.
// ----------------------------------------------------------------------------
module json_string_unescape (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,     // lowercase_output
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [7:0] in_byte
    input  logic       s_tlast,       // last_item
    input  logic [1:0] s_tuser,       // [0] first_item, [1] quoted
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // [7:0] out_byte
    output logic       m_tlast,       // end_of_string
    output logic [0:0] m_tuser        // [0] byte_valid
);
    import jsu_pkg::*;

    logic lower_reg;
    logic in_accept;
    logic push, pop, full, empty;
    cmd_t push_cmd, pop_cmd;

    assign s_tready  = !full;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg <= 1'b0;
        end else if (cfg_we) begin
            lower_reg <= cfg_wdata;
        end
    end

    jsu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_byte    (s_tdata),
        .first_item (s_tuser[0]),
        .last_item  (s_tlast),
        .quoted     (s_tuser[1]),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    jsu_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    jsu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .lower    (lower_reg),
        .empty    (empty),
        .pop_cmd  (pop_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_bare_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tdata == 8'h00))
        else $error("bare marker not at end of string");

    a_lowercase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && lower_reg) |-> !(m_tdata >= CH_UP_A && m_tdata <= CH_UP_Z))
        else $error("uppercase byte emitted in lowercase mode");

    a_last_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_tlast) |-> push)
        else $error("end of string produced no request");

endmodule
